>>> sv/dmul_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal digit multiplier package
// Shared sizes, transaction payload types, sequencer states and the
// control bundle of the arithmetic unit.
// ----------------------------------------------------------------------------
package dmul_pkg;

    // Operand size and derived widths.
    localparam int MAX_DIGITS = 32;
    localparam int DIGIT_W    = 4;
    localparam int DIG_AW     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int NUM_COLS   = 2 * MAX_DIGITS;
    localparam int COL_W      = $clog2(NUM_COLS);
    localparam int NCOL_W     = $clog2(NUM_COLS + 1);

    // Column accumulator; a column plus incoming carry stays far below 2**16.
    localparam int ACC_W      = 16;

    // Division by ten as a multiply by a scaled reciprocal and a shift.
    localparam int              DIV10_MUL_W = 16;
    localparam int              MUL_W       = ACC_W + DIV10_MUL_W;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 16'd52429;
    localparam int              DIV10_SH    = 19;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
    localparam logic [CNT_W-1:0]   MAX_CNT   = CNT_W'(MAX_DIGITS);

    // One incoming transaction.
    typedef struct packed {
        logic               req_type;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_in_item;

    // One outgoing transaction.
    typedef struct packed {
        logic [DIGIT_W-1:0] product_digit;
        logic               last_digit;
        logic               too_long;
    } t_out_item;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_COL,
        ST_MAC,
        ST_QUOT,
        ST_DIGIT,
        ST_RD,
        ST_EMIT
    } t_state;

    // Operations of the shared arithmetic unit.
    typedef enum logic [2:0] {
        ALU_HOLD,
        ALU_INIT,
        ALU_MAC,
        ALU_QUOT,
        ALU_DIGIT
    } t_alu_op;

    typedef struct packed {
        t_alu_op op;
        logic    carry_clr;
    } t_alu_ctl;

endpackage
`default_nettype wire

>>> sv/dmul_opmem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Operand digit stores
// Two digit memories, one per operand, with one write port shared by both
// and one registered read port each.
// ----------------------------------------------------------------------------
module dmul_opmem (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic                           i_sel,
    input  wire logic [dmul_pkg::DIG_AW-1:0]    i_waddr,
    input  wire logic [dmul_pkg::DIGIT_W-1:0]   i_wdata,
    input  wire logic [dmul_pkg::DIG_AW-1:0]    i_raddr_a,
    input  wire logic [dmul_pkg::DIG_AW-1:0]    i_raddr_b,
    output logic      [dmul_pkg::DIGIT_W-1:0]   o_rdata_a,
    output logic      [dmul_pkg::DIGIT_W-1:0]   o_rdata_b
);
    import dmul_pkg::*;

    logic [DIGIT_W-1:0] r_first_mem  [MAX_DIGITS];
    logic [DIGIT_W-1:0] r_second_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] r_rd_a;
    logic [DIGIT_W-1:0] r_rd_b;

    // Digit writes; i_sel picks the second operand.
    always_ff @(posedge i_clk) begin
        if (i_we && !i_sel) begin
            r_first_mem[i_waddr] <= i_wdata;
        end
        if (i_we && i_sel) begin
            r_second_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered reads, one per operand.
    always_ff @(posedge i_clk) begin
        r_rd_a <= r_first_mem[i_raddr_a];
        r_rd_b <= r_second_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule
`default_nettype wire

>>> sv/dmul_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// Accumulates digit products of one column, then splits the column into a
// base-ten digit and a carry into the next column.
// ----------------------------------------------------------------------------
module dmul_alu (
    input  wire logic                           i_clk,
    input  wire dmul_pkg::t_alu_ctl             i_ctl,
    input  wire logic [dmul_pkg::DIGIT_W-1:0]   i_a,
    input  wire logic [dmul_pkg::DIGIT_W-1:0]   i_b,
    output logic      [dmul_pkg::DIGIT_W-1:0]   o_digit
);
    import dmul_pkg::*;

    logic [ACC_W-1:0]     r_acc;
    logic [ACC_W-1:0]     r_quot;
    logic [ACC_W-1:0]     r_carry;
    logic [2*DIGIT_W-1:0] prod;
    logic [MUL_W-1:0]     recip;
    logic [ACC_W-1:0]     quot_next;
    logic [ACC_W-1:0]     tens;
    logic [ACC_W-1:0]     rem;

    // Digit product and the reciprocal multiply for the quotient by ten.
    assign prod      = i_a * i_b;
    assign recip     = MUL_W'(r_acc) * MUL_W'(DIV10_MUL);
    assign quot_next = ACC_W'(recip >> DIV10_SH);

    // Remainder from the registered quotient: acc - 10 * quot.
    assign tens    = (r_quot << 3) + (r_quot << 1);
    assign rem     = r_acc - tens;
    assign o_digit = rem[DIGIT_W-1:0];

    // Accumulator, quotient and carry registers.
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            ALU_INIT:  r_acc   <= r_carry;
            ALU_MAC:   r_acc   <= r_acc + ACC_W'(prod);
            ALU_QUOT:  r_quot  <= quot_next;
            ALU_DIGIT: r_carry <= r_quot;
            default: begin
            end
        endcase
        if (i_ctl.carry_clr) begin
            r_carry <= '0;
        end
    end

endmodule
`default_nettype wire

>>> sv/dmul_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multiplier sequencer
// Loads operand digits, walks the columns of the product pair by pair,
// stores the product digits and sends them out most significant first.
// ----------------------------------------------------------------------------
module dmul_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire dmul_pkg::t_in_item             i_in,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output dmul_pkg::t_out_item                 o_out,
    output logic                                o_mem_we,
    output logic                                o_mem_sel,
    output logic      [dmul_pkg::DIG_AW-1:0]    o_mem_waddr,
    output logic      [dmul_pkg::DIGIT_W-1:0]   o_mem_wdata,
    output logic      [dmul_pkg::DIG_AW-1:0]    o_raddr_a,
    output logic      [dmul_pkg::DIG_AW-1:0]    o_raddr_b,
    output dmul_pkg::t_alu_ctl                  o_alu_ctl,
    input  wire logic [dmul_pkg::DIGIT_W-1:0]   i_digit
);
    import dmul_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_first_cnt;
    logic [CNT_W-1:0]    r_second_cnt;
    logic                r_ovf;
    logic [COL_W-1:0]    r_col;
    logic [NCOL_W-1:0]   r_i;
    logic [NCOL_W-1:0]   r_ihi;
    logic                r_pv;
    logic [COL_W-1:0]    r_top;
    logic [COL_W-1:0]    r_e;
    logic [DIGIT_W-1:0]  r_res_mem [NUM_COLS];
    logic [DIGIT_W-1:0]  r_res_rd;

    logic                in_acc;
    logic                out_acc;
    logic [DIGIT_W-1:0]  dsat;
    logic [CNT_W-1:0]    cur_cnt;
    logic                room;
    logic                ops_nz;
    logic [NCOL_W-1:0]   ncols;
    logic [NCOL_W-1:0]   col_ext;
    logic [NCOL_W-1:0]   m_ext;
    logic [NCOL_W-1:0]   n_ext;
    logic                col_last;
    logic [NCOL_W-1:0]   ilo;
    logic [NCOL_W-1:0]   ihi;
    logic                issue;
    logic [NCOL_W-1:0]   addr_a;
    logic [NCOL_W-1:0]   addr_b;
    logic [COL_W-1:0]    top_next;

    // Handshake terms.
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // Load side: saturate the digit and pick the operand count.
    assign dsat    = (i_in.digit > DIGIT_MAX) ? DIGIT_MAX : i_in.digit;
    assign cur_cnt = i_in.req_type ? r_second_cnt : r_first_cnt;
    assign room    = cur_cnt < MAX_CNT;

    // Column bounds: pairs (i, c - i) with both digit indexes in range.
    assign m_ext    = NCOL_W'(r_first_cnt);
    assign n_ext    = NCOL_W'(r_second_cnt);
    assign col_ext  = NCOL_W'(r_col);
    assign ops_nz   = (r_first_cnt != '0) && (r_second_cnt != '0);
    assign ncols    = m_ext + n_ext;
    assign col_last = (col_ext + NCOL_W'(1)) >= ncols;
    assign ilo      = (col_ext >= n_ext) ? (col_ext - n_ext + NCOL_W'(1)) : '0;
    assign ihi      = (col_ext < (m_ext - NCOL_W'(1))) ? col_ext : (m_ext - NCOL_W'(1));
    assign issue    = (r_state == ST_MAC) && ops_nz && (r_i <= r_ihi);

    // Digits are stored most significant first, columns count from the bottom.
    assign addr_a   = m_ext - NCOL_W'(1) - r_i;
    assign addr_b   = n_ext - NCOL_W'(1) - col_ext + r_i;
    assign top_next = (i_digit != '0) ? r_col : r_top;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_acc && i_in.req_type && i_in.last) begin
                    n_state = ST_COL;
                end
            end
            ST_COL:   n_state = ST_MAC;
            ST_MAC: begin
                if (!issue && !r_pv) begin
                    n_state = ST_QUOT;
                end
            end
            ST_QUOT:  n_state = ST_DIGIT;
            ST_DIGIT: n_state = col_last ? ST_RD : ST_COL;
            ST_RD:    n_state = ST_EMIT;
            ST_EMIT: begin
                if (!i_stall) begin
                    n_state = (r_e == '0) ? ST_LOAD : ST_RD;
                end
            end
            default:  n_state = ST_LOAD;
        endcase
    end

    // State-driven outputs.
    always_comb begin
        o_stall             = 1'b1;
        o_valid             = 1'b0;
        o_mem_we            = 1'b0;
        o_alu_ctl.op        = ALU_HOLD;
        o_alu_ctl.carry_clr = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_stall             = 1'b0;
                o_mem_we            = i_valid && room;
                o_alu_ctl.carry_clr = i_valid && i_in.req_type && i_in.last;
            end
            ST_COL:   o_alu_ctl.op = ALU_INIT;
            ST_MAC:   o_alu_ctl.op = r_pv ? ALU_MAC : ALU_HOLD;
            ST_QUOT:  o_alu_ctl.op = ALU_QUOT;
            ST_DIGIT: o_alu_ctl.op = ALU_DIGIT;
            ST_EMIT:  o_valid      = 1'b1;
            default: begin
            end
        endcase
    end

    assign o_mem_sel   = i_in.req_type;
    assign o_mem_waddr = cur_cnt[DIG_AW-1:0];
    assign o_mem_wdata = dsat;
    assign o_raddr_a   = addr_a[DIG_AW-1:0];
    assign o_raddr_b   = addr_b[DIG_AW-1:0];

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_ovf        <= 1'b0;
            r_pv         <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        if (!room) begin
                            r_ovf <= 1'b1;
                        end else if (i_in.req_type) begin
                            r_second_cnt <= r_second_cnt + CNT_W'(1);
                        end else begin
                            r_first_cnt <= r_first_cnt + CNT_W'(1);
                        end
                    end
                end
                ST_COL: r_pv <= 1'b0;
                ST_MAC: r_pv <= issue;
                ST_EMIT: begin
                    if (out_acc && (r_e == '0)) begin
                        r_first_cnt  <= '0;
                        r_second_cnt <= '0;
                        r_ovf        <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Column walk and emission counters.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                r_col <= '0;
                r_top <= '0;
            end
            ST_COL: begin
                r_i   <= ilo;
                r_ihi <= ihi;
            end
            ST_MAC: begin
                if (issue) begin
                    r_i <= r_i + NCOL_W'(1);
                end
            end
            ST_DIGIT: begin
                r_top <= top_next;
                if (col_last) begin
                    r_e <= top_next;
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            ST_EMIT: begin
                if (out_acc && (r_e != '0)) begin
                    r_e <= r_e - COL_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Product digit store, written per column and read for emission.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIGIT) begin
            r_res_mem[r_col] <= i_digit;
        end
        if (r_state == ST_RD) begin
            r_res_rd <= r_res_mem[r_e];
        end
    end

    // Result transaction, held steady while stalled.
    assign o_out.product_digit = r_res_rd;
    assign o_out.last_digit    = (r_e == '0);
    assign o_out.too_long      = r_ovf;

endmodule
`default_nettype wire

>>> sv/decimal_digit_multiplier_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal digit multiplier
// Schoolbook multiplication of two decimal operands loaded digit by digit.
// ----------------------------------------------------------------------------
// While loading, the block takes a digit whenever one is offered. The digit
// of the second operand marked last starts the product; the block then
// stalls its input until the final product digit has been taken. One
// multiply-accumulate unit and one read port per operand store do all the
// work: each column sums its digit pairs, then a divide-by-ten step splits
// off the carry. Each product digit is read from the result store and then
// sent, most significant first, without leading zeros. Operands longer than
// the store keep their leading digits and flag too_long on every product
// digit.
module decimal_digit_multiplier_top (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire dmul_pkg::t_in_item  i_in,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output dmul_pkg::t_out_item      o_out
);
    import dmul_pkg::*;

    logic                mem_we;
    logic                mem_sel;
    logic [DIG_AW-1:0]   mem_waddr;
    logic [DIGIT_W-1:0]  mem_wdata;
    logic [DIG_AW-1:0]   raddr_a;
    logic [DIG_AW-1:0]   raddr_b;
    logic [DIGIT_W-1:0]  rdata_a;
    logic [DIGIT_W-1:0]  rdata_b;
    t_alu_ctl            alu_ctl;
    logic [DIGIT_W-1:0]  digit;

    // Sequencer.
    dmul_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .o_mem_we    (mem_we),
        .o_mem_sel   (mem_sel),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_raddr_a   (raddr_a),
        .o_raddr_b   (raddr_b),
        .o_alu_ctl   (alu_ctl),
        .i_digit     (digit)
    );

    // Operand stores.
    dmul_opmem u_opmem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_sel     (mem_sel),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Shared multiply-accumulate and carry unit.
    dmul_alu u_alu (
        .i_clk   (i_clk),
        .i_ctl   (alu_ctl),
        .i_a     (rdata_a),
        .i_b     (rdata_b),
        .o_digit (digit)
    );

endmodule
`default_nettype wire

>>> sv/dmul_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Decimal digit multiplier port checker
// Watches the top-level ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module dmul_checker (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic                 o_stall,
    input  wire dmul_pkg::t_in_item   i_in,
    input  wire logic                 o_valid,
    input  wire logic                 i_stall,
    input  wire dmul_pkg::t_out_item  o_out
);
    import dmul_pkg::*;

    // A stalled result transaction stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out))
        else $error("result transaction changed while stalled");

    // No digit is taken while a product is being sent.
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while product digits are pending");

    // The final digit of the second operand starts the product.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_in.req_type && i_in.last |=> o_stall)
        else $error("input still open after product start");

    // Once the final product digit is taken, loading resumes.
    a_done_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_out.last_digit |=> !o_stall && !o_valid)
        else $error("block not ready after final product digit");

    // Product digits are always decimal.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_out.product_digit <= DIGIT_MAX)
        else $error("product digit out of decimal range");

endmodule

bind decimal_digit_multiplier_top dmul_checker u_dmul_checker (.*);
`default_nettype wire

>>> dv/tb_decimal_digit_multiplier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal digit multiplier testbench
// Streams operand digits into the block with random gaps and output
// back-pressure, predicts every product digit, and checks them in order.
// ----------------------------------------------------------------------------
module tb_decimal_digit_multiplier_top;
    import dmul_pkg::*;

    localparam logic OPERAND_A      = 1'b0;
    localparam logic OPERAND_B      = 1'b1;
    localparam int   DEC_BASE       = 10;
    localparam int   RANDOM_ITEMS   = 400;
    localparam int   IDLE_PCT       = 35;
    localparam int   STEADY_FROM    = 150;
    localparam int   STEADY_TO      = 250;
    localparam int   HOLD_LEN       = 400;
    localparam int   HOLD_SEQ       = 3;
    localparam int   PAUSE_SEQ      = 8;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   DRAIN_CYCLES   = 200;
    localparam int   REPORT_MAX     = 10;
    localparam int   NUM_DIR        = 25;

    // One row of the directed table: an item, how often it is sent, and an
    // optional typed-in single-digit product for the row's last transaction.
    typedef struct packed {
        t_in_item   item;
        logic [5:0] reps;
        logic       typed;
        t_out_item  result;
    } t_dir_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_in    = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_out;

    // Product predictor state.
    logic [DIGIT_W-1:0] first_op  [MAX_DIGITS];
    logic [DIGIT_W-1:0] second_op [MAX_DIGITS];
    int                 first_len  = 0;
    int                 second_len = 0;
    bit                 truncated  = 1'b0;
    t_out_item          new_digits [$];
    t_out_item          awaited_digits [$];

    int fault_cnt   = 0;
    int sent        = 0;
    int hold_cycles = 0;
    bit steady      = 1'b0;

    t_dir_row dir_rows [NUM_DIR] = '{
        // Empty first operand times zero.
        '{'{OPERAND_B, 4'd0, 1'b1},  6'd1,  1'b1, '{4'd0, 1'b1, 1'b0}},
        // Last flag on a first-operand digit is ignored; 0 x 7.
        '{'{OPERAND_A, 4'd0, 1'b1},  6'd1,  1'b0, '0},
        '{'{OPERAND_B, 4'd7, 1'b1},  6'd1,  1'b1, '{4'd0, 1'b1, 1'b0}},
        // Digits above nine saturate: 15 x 15 reads as 9 x 9.
        '{'{OPERAND_A, 4'd15, 1'b0}, 6'd1,  1'b0, '0},
        '{'{OPERAND_B, 4'd15, 1'b1}, 6'd1,  1'b0, '0},
        // 1 x 9.
        '{'{OPERAND_A, 4'd1, 1'b0},  6'd1,  1'b0, '0},
        '{'{OPERAND_B, 4'd9, 1'b1},  6'd1,  1'b1, '{4'd9, 1'b1, 1'b0}},
        // Zero product with leading zeros dropped: 10 x 0.
        '{'{OPERAND_A, 4'd1, 1'b0},  6'd1,  1'b0, '0},
        '{'{OPERAND_A, 4'd0, 1'b0},  6'd1,  1'b0, '0},
        '{'{OPERAND_B, 4'd0, 1'b1},  6'd1,  1'b1, '{4'd0, 1'b1, 1'b0}},
        // First operand one digit too long: the flag rides on the product.
        '{'{OPERAND_A, 4'd0, 1'b0},  6'd33, 1'b0, '0},
        '{'{OPERAND_B, 4'd3, 1'b1},  6'd1,  1'b1, '{4'd0, 1'b1, 1'b1}},
        // The flag is cleared for the next product: 2 x 4.
        '{'{OPERAND_A, 4'd2, 1'b0},  6'd1,  1'b0, '0},
        '{'{OPERAND_B, 4'd4, 1'b1},  6'd1,  1'b1, '{4'd8, 1'b1, 1'b0}},
        // Remaining codes above nine.
        '{'{OPERAND_A, 4'd10, 1'b0}, 6'd1,  1'b0, '0},
        '{'{OPERAND_A, 4'd11, 1'b0}, 6'd1,  1'b0, '0},
        '{'{OPERAND_B, 4'd12, 1'b0}, 6'd1,  1'b0, '0},
        '{'{OPERAND_B, 4'd13, 1'b0}, 6'd1,  1'b0, '0},
        '{'{OPERAND_B, 4'd14, 1'b1}, 6'd1,  1'b0, '0},
        // Empty first operand, two-digit second operand.
        '{'{OPERAND_B, 4'd2, 1'b0},  6'd1,  1'b0, '0},
        '{'{OPERAND_B, 4'd5, 1'b1},  6'd1,  1'b1, '{4'd0, 1'b1, 1'b0}},
        // Trailing zeros survive: 50 x 20.
        '{'{OPERAND_A, 4'd5, 1'b0},  6'd1,  1'b0, '0},
        '{'{OPERAND_A, 4'd0, 1'b0},  6'd1,  1'b0, '0},
        '{'{OPERAND_B, 4'd2, 1'b0},  6'd1,  1'b0, '0},
        '{'{OPERAND_B, 4'd0, 1'b1},  6'd1,  1'b0, '0}
    };

    always #5 i_clk = ~i_clk;

    decimal_digit_multiplier_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out)
    );

    // Load one accepted digit; on the last digit of the second operand,
    // multiply column by column and leave the product digits in new_digits.
    function automatic void absorb_digit(input t_in_item it);
        logic [DIGIT_W-1:0] d;
        int unsigned        cols [2*MAX_DIGITS+1];
        int                 i;
        int                 j;
        int                 top;
        t_out_item          pd;
        new_digits.delete();
        d = (it.digit > DIGIT_MAX) ? DIGIT_MAX : it.digit;
        if (it.req_type == OPERAND_A) begin
            if (first_len < MAX_DIGITS) begin
                first_op[first_len] = d;
                first_len++;
            end else begin
                truncated = 1'b1;
            end
            return;
        end
        if (second_len < MAX_DIGITS) begin
            second_op[second_len] = d;
            second_len++;
        end else begin
            truncated = 1'b1;
        end
        if (!it.last) begin
            return;
        end
        foreach (cols[c]) cols[c] = 0;
        for (i = 0; i < first_len; i++) begin
            for (j = 0; j < second_len; j++) begin
                cols[i+j] += first_op[first_len-1-i] * second_op[second_len-1-j];
            end
        end
        // Carry propagation, least significant column first.
        for (i = 0; i < 2*MAX_DIGITS; i++) begin
            cols[i+1] += cols[i] / DEC_BASE;
            cols[i]    = cols[i] % DEC_BASE;
        end
        top = 2*MAX_DIGITS - 1;
        while (top > 0 && cols[top] == 0) top--;
        for (i = top; i >= 0; i--) begin
            pd.product_digit = DIGIT_W'(cols[i]);
            pd.last_digit    = (i == 0);
            pd.too_long      = truncated;
            new_digits.push_back(pd);
        end
        first_len  = 0;
        second_len = 0;
        truncated  = 1'b0;
    endfunction

    function automatic void report_fault(input string what, input t_out_item want,
                                         input t_out_item got);
        fault_cnt++;
        if (fault_cnt <= REPORT_MAX) begin
            $display("%t %s: expected digit %0d last %0b too_long %0b, %s",
                     $realtime, what, want.product_digit, want.last_digit, want.too_long,
                     $sformatf("got digit %0d last %0b too_long %0b",
                               got.product_digit, got.last_digit, got.too_long));
        end
    endfunction

    function automatic logic [DIGIT_W-1:0] pick_digit();
        if ($urandom_range(9) == 0) begin
            return DIGIT_W'($urandom_range(15));
        end
        return DIGIT_W'($urandom_range(9));
    endfunction

    // Mostly short operands, some long ones, a few past the store size.
    function automatic int pick_len(input int lo);
        int r;
        r = $urandom_range(99);
        if (r < 70) begin
            return $urandom_range(6, lo);
        end else if (r < 92) begin
            return $urandom_range(31, 7);
        end
        return $urandom_range(36, 32);
    endfunction

    // Offer one transaction, with random gaps before it, and predict on accept.
    task automatic offer(input t_in_item it, input bit typed, input t_out_item fixed);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= it;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        absorb_digit(it);
        if (typed) begin
            awaited_digits.push_back(fixed);
        end else begin
            foreach (new_digits[k]) awaited_digits.push_back(new_digits[k]);
        end
    endtask

    // One multiplication: first operand, then second operand ending in last,
    // with the odd first-operand digit slipped in between.
    task automatic send_product(input int a_cnt, input int b_cnt);
        t_in_item it;
        int       k;
        for (k = 0; k < a_cnt; k++) begin
            it.req_type = OPERAND_A;
            it.digit    = pick_digit();
            it.last     = ($urandom_range(9) == 0);
            offer(it, 1'b0, '0);
            sent++;
        end
        for (k = 0; k < b_cnt; k++) begin
            if ($urandom_range(11) == 0) begin
                it.req_type = OPERAND_A;
                it.digit    = pick_digit();
                it.last     = 1'($urandom_range(1));
                offer(it, 1'b0, '0);
                sent++;
            end
            it.req_type = OPERAND_B;
            it.digit    = pick_digit();
            it.last     = (k == b_cnt - 1);
            offer(it, 1'b0, '0);
            sent++;
        end
    endtask

    // Stimulus: reset, directed table, random products, then drain.
    initial begin
        int r;
        int k;
        int seq;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (r = 0; r < NUM_DIR; r++) begin
            for (k = 0; k < dir_rows[r].reps; k++) begin
                offer(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].result);
            end
        end
        seq = 0;
        while (sent < RANDOM_ITEMS) begin
            steady = (sent >= STEADY_FROM && sent < STEADY_TO);
            if (seq == HOLD_SEQ) begin
                hold_cycles = HOLD_LEN;
            end
            if (seq == PAUSE_SEQ) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (awaited_digits.size() != 0);
            end
            send_product(pick_len(0), pick_len(1));
            seq++;
        end
        i_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_digits.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Result side: check each accepted transaction, then pick the next stall.
    initial begin
        t_out_item want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
                if (awaited_digits.size() == 0) begin
                    report_fault("unexpected product digit", '0, o_out);
                end else begin
                    want = awaited_digits.pop_front();
                    if (o_out.product_digit !== want.product_digit ||
                        o_out.last_digit !== want.last_digit ||
                        o_out.too_long !== want.too_long) begin
                        report_fault("product digit mismatch", want, o_out);
                    end
                end
            end
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
